// ===== hdl/rse_pkg.sv =====
// Shared types and constants of the Reed-Solomon systematic encoder.
package rse_pkg;

  // Port widths set by the stream and register formats.
  localparam int SYM_W       = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int POLY_W      = 9;
  localparam int GEN_COEFS   = 17;

  // Register map of the configuration channel.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FIELD_POLY   = 3'd0,
    CFG_GEN_REVERSED = 3'd1,
    CFG_GEN_LOW      = 3'd2,
    CFG_GEN_MID      = 3'd3,
    CFG_GEN_TOP      = 3'd4,
    CFG_OFFSET_LOW   = 3'd5,
    CFG_OFFSET_HIGH  = 3'd6
  } cfg_index_t;

  // One output word as it sits in the output or skid register.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             par;
    logic             last;
  } out_word_t;

endpackage

// ===== hdl/rs_systematic_encoder.sv =====
// Systematic Reed-Solomon encoder over GF(2^SYMBOL_BITS) with a streaming interface.
//
// Message symbols enter on the slave stream, one word per cycle while s_tready is high,
// and leave unchanged on the master stream with tuser low. Each symbol also drives a
// parallel LFSR: the feedback symbol (input XOR remainder head) is multiplied by all
// generator taps at once and folded into the remainder in the same cycle. When the word
// carrying tlast is taken, the encoder follows its echo with PARITY_SYMBOLS parity words
// (tuser high, tlast on the final one); each is the remainder head XOR its initial-status
// word, shifted out of the remainder one per cycle while the skid register is empty,
// which leaves the remainder cleared for the next codeword; meanwhile s_tready is low.
// An output register and a one-word skid register sit behind the LFSR, so s_tready
// comes from registers only, and a word is still taken while the previous result waits.
// The configuration channel is always ready; writes are meant to land between
// codewords, with the block idle. Indexes outside the register map are ignored.
module rs_systematic_encoder #(
  parameter int SYMBOL_BITS    = 8,
  parameter int PARITY_SYMBOLS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // Slave stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rse_pkg::SYM_W-1:0]      s_tdata,   // [7:0] data_symbol
  input  logic                           s_tlast,   // last_data
  // Master stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rse_pkg::SYM_W-1:0]      m_tdata,   // [7:0] code_symbol
  output logic                           m_tuser,   // is_parity
  output logic                           m_tlast,   // last_out
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rse_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SB    = SYMBOL_BITS;
  localparam int P     = PARITY_SYMBOLS;
  localparam int CNT_W = $clog2(PARITY_SYMBOLS);

  // Carry-less multiply with reduction by the low SB bits of the field polynomial.
  function automatic logic [SB-1:0] gf_mul(input logic [SB-1:0] a_in,
                                           input logic [SB-1:0] b,
                                           input logic [SB-1:0] red);
    logic [SB-1:0] a;
    logic [SB-1:0] acc;
    a   = a_in;
    acc = '0;
    for (int i = 0; i < SB; i++) begin
      if (b[i]) acc = acc ^ a;
      a = {a[SB-2:0], 1'b0} ^ (a[SB-1] ? red : '0);
    end
    return acc;
  endfunction

  // Configuration registers.
  logic [rse_pkg::POLY_W-1:0]     field_poly;
  logic                           gen_rev;
  logic [rse_pkg::CFG_DATA_W-1:0] gen_low;
  logic [rse_pkg::CFG_DATA_W-1:0] gen_mid;
  logic [7:0]                     gen_top;
  logic [rse_pkg::CFG_DATA_W-1:0] off_low;
  logic [rse_pkg::CFG_DATA_W-1:0] off_high;

  // Datapath state.
  logic [SB-1:0]           rem      [0:P-1];
  logic [SB-1:0]           rem_next [0:P-1];
  logic                    emitting;
  logic [CNT_W-1:0]        cnt;
  logic                    sk_valid;
  rse_pkg::out_word_t      sk_word;
  rse_pkg::out_word_t      new_word;

  logic [7:0]              gen_byte [0:rse_pkg::GEN_COEFS-1];
  logic [SB-1:0]           tap      [1:P];
  logic [SB-1:0]           off_sym  [0:P-1];
  logic [SB-1:0]           red;
  logic [SB-1:0]           fb;
  logic                    in_fire;
  logic                    par_fire;
  logic                    par_done;
  logic                    out_load_ok;

  assign cfg_ready = 1'b1;

  // Generator coefficients laid out as bytes; only the low SB bits take part.
  for (genvar g = 0; g < rse_pkg::GEN_COEFS; g++) begin : g_gen
    if (g < 8) begin : g_lo
      assign gen_byte[g] = gen_low[8*g +: 8];
    end else if (g < 16) begin : g_mid
      assign gen_byte[g] = gen_mid[8*(g-8) +: 8];
    end else begin : g_top
      assign gen_byte[g] = gen_top;
    end
  end

  // Tap j weighs the feedback into remainder position j-1; order set by gen_rev.
  for (genvar j = 1; j <= P; j++) begin : g_tap
    assign tap[j] = gen_rev ? gen_byte[j][SB-1:0] : gen_byte[P-j][SB-1:0];
  end

  for (genvar k = 0; k < P; k++) begin : g_off
    if (k < 8) begin : g_lo
      assign off_sym[k] = off_low[8*k +: SB];
    end else begin : g_hi
      assign off_sym[k] = off_high[8*(k-8) +: SB];
    end
  end

  assign red         = field_poly[SB-1:0];
  assign fb          = s_tdata[SB-1:0] ^ rem[0];
  assign s_tready    = !emitting && !sk_valid;
  assign in_fire     = s_tvalid && s_tready;
  assign par_fire    = emitting && !sk_valid;
  assign par_done    = (cnt == CNT_W'(P - 1));
  assign out_load_ok = !m_tvalid || m_tready;

  always_comb begin
    for (int t = 0; t < P; t++) rem_next[t] = rem[t];
    new_word = '0;
    if (in_fire) begin
      for (int t = 0; t < P - 1; t++) rem_next[t] = rem[t+1] ^ gf_mul(fb, tap[t+1], red);
      rem_next[P-1] = gf_mul(fb, tap[P], red);
      new_word.sym  = rse_pkg::SYM_W'(s_tdata[SB-1:0]);
    end else if (par_fire) begin
      // Shift the remainder out from the head; zeros enter at the tail.
      for (int t = 0; t < P - 1; t++) rem_next[t] = rem[t+1];
      rem_next[P-1] = '0;
      new_word.sym  = rse_pkg::SYM_W'(rem[0] ^ off_sym[cnt]);
      new_word.par  = 1'b1;
      new_word.last = par_done;
    end
  end

  // Control state, remainder and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_poly <= rse_pkg::POLY_W'(285);
      gen_rev    <= 1'b0;
      gen_low    <= '0;
      gen_mid    <= '0;
      gen_top    <= 8'd1;
      off_low    <= '0;
      off_high   <= '0;
      for (int t = 0; t < P; t++) rem[t] <= '0;
      emitting   <= 1'b0;
      cnt        <= '0;
      sk_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (rse_pkg::cfg_index_t'(cfg_index))
          rse_pkg::CFG_FIELD_POLY:   field_poly <= cfg_data[rse_pkg::POLY_W-1:0];
          rse_pkg::CFG_GEN_REVERSED: gen_rev    <= cfg_data[0];
          rse_pkg::CFG_GEN_LOW:      gen_low    <= cfg_data;
          rse_pkg::CFG_GEN_MID:      gen_mid    <= cfg_data;
          rse_pkg::CFG_GEN_TOP:      gen_top    <= cfg_data[7:0];
          rse_pkg::CFG_OFFSET_LOW:   off_low    <= cfg_data;
          rse_pkg::CFG_OFFSET_HIGH:  off_high   <= cfg_data;
          default: ;
        endcase
      end
      for (int t = 0; t < P; t++) rem[t] <= rem_next[t];
      if (in_fire && s_tlast) begin
        emitting <= 1'b1;
        cnt      <= '0;
      end else if (par_fire) begin
        if (par_done) begin
          emitting <= 1'b0;
          cnt      <= '0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      if (out_load_ok) begin
        if (sk_valid) begin
          m_tvalid <= 1'b1;
          sk_valid <= 1'b0;
        end else begin
          m_tvalid <= in_fire || par_fire;
        end
      end else if (in_fire || par_fire) begin
        sk_valid <= 1'b1;
      end
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (out_load_ok) begin
      if (sk_valid) begin
        {m_tdata, m_tuser, m_tlast} <= sk_word;
      end else if (in_fire || par_fire) begin
        {m_tdata, m_tuser, m_tlast} <= new_word;
      end
    end else if (in_fire || par_fire) begin
      sk_word <= new_word;
    end
  end

endmodule

// ===== hdl/rse_checker.sv =====
// Port-level checks of the Reed-Solomon encoder and their binding.
module rse_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rse_pkg::SYM_W-1:0] m_tdata,
  input logic                      m_tuser,
  input logic                      m_tlast
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output word changed while stalled");

  // Only a parity word closes a codeword.
  a_last_parity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("end of codeword on a message word");

  // While parity words are still coming, no message word is taken.
  a_no_input_in_parity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && !m_tlast |-> !s_tready)
    else $error("message word taken during parity output");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

endmodule

bind rs_systematic_encoder rse_checker u_rse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/tb_rs_systematic_encoder.sv =====
// Self-checking testbench for the streaming Reed-Solomon systematic encoder.
module tb_rs_systematic_encoder;

  // The encoder is used at its default size: 8-bit symbols, 16 parity symbols.
  localparam int PARITY_N     = 16;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_WORDS  = 100;
  localparam int N_ROWS       = 20;

  // An index that lies outside the register map; the encoder must ignore it.
  localparam logic [rse_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

  // One complete register setting.
  typedef struct {
    logic [8:0]  poly;
    logic        rev;
    logic [63:0] gen_low;
    logic [63:0] gen_mid;
    logic [7:0]  gen_top;
    logic [63:0] off_low;
    logic [63:0] off_high;
  } reg_set_t;

  // One row of the directed stimulus. Rows marked typed carry their own expected echo and
  // parity value; all other rows are checked against the encoder model below.
  typedef struct {
    logic [7:0] data;
    logic       last;
    int         setting;
    bit         typed;
    logic [7:0] echo_exp;
    logic [7:0] parity_exp;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [rse_pkg::SYM_W-1:0]       s_tdata   = '0;   // [7:0] data_symbol
  logic                            s_tlast   = 1'b0; // last_data
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [rse_pkg::SYM_W-1:0]       m_tdata;          // [7:0] code_symbol
  logic                            m_tuser;          // is_parity
  logic                            m_tlast;          // last_out
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rse_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rse_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  rs_systematic_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model copy of the registers and of the parity remainder.
  logic [8:0]  field_poly_q;
  logic        gen_reversed_q;
  logic [63:0] gen_low_q;
  logic [63:0] gen_mid_q;
  logic [7:0]  gen_top_q;
  logic [63:0] offset_low_q;
  logic [63:0] offset_high_q;
  logic [7:0]  remainder_q [PARITY_N];

  rse_pkg::out_word_t code_words_due [$];   // words still owed by the encoder, oldest first
  rse_pkg::out_word_t predicted_words [$];  // words caused by the most recent input word

  int mismatches    = 0;
  int src_idle_pct  = 13;
  int snk_idle_pct  = 64;
  int hold_requests = 0;
  int holds_done    = 0;

  // Settings used by the directed rows. Setting 0 is the state after reset and is never
  // written; the others take the polynomial, and setting 1 the coefficients, to extremes.
  reg_set_t directed_sets [4] = '{
    '{9'd285, 1'b0, 64'd0, 64'd0, 8'd1, 64'd0, 64'd0},
    '{9'h1FF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
    '{9'h100, 1'b0, 64'h0807_0605_0403_0201, 64'h100F_0E0D_0C0B_0A09, 8'h11,
      64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210},
    '{9'h000, 1'b1, 64'h8040_2010_0804_0201, 64'h0000_0000_0000_0000, 8'h80,
      64'h0000_0000_0000_0000, 64'h5A5A_5A5A_A5A5_A5A5}
  };

  // After reset every tap weight is zero, so the remainder never moves and each parity
  // symbol is its offset word, which is also zero. Those rows can be typed in directly.
  stim_row_t directed_rows [N_ROWS] = '{
    '{8'h00, 1'b0, 0, 1'b1, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 0, 1'b1, 8'hFF, 8'h00},
    '{8'h01, 1'b0, 0, 1'b1, 8'h01, 8'h00},
    '{8'h80, 1'b1, 0, 1'b1, 8'h80, 8'h00},
    '{8'h55, 1'b1, 0, 1'b1, 8'h55, 8'h00},
    '{8'hAA, 1'b0, 0, 1'b1, 8'hAA, 8'h00},
    '{8'h7F, 1'b1, 0, 1'b1, 8'h7F, 8'h00},
    '{8'hFF, 1'b0, 1, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 1'b1, 1, 1'b0, 8'h00, 8'h00},
    '{8'h01, 1'b1, 1, 1'b0, 8'h00, 8'h00},
    '{8'h80, 1'b0, 2, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 2, 1'b0, 8'h00, 8'h00},
    '{8'h03, 1'b1, 2, 1'b0, 8'h00, 8'h00},
    '{8'h80, 1'b1, 2, 1'b0, 8'h00, 8'h00},
    '{8'h12, 1'b0, 3, 1'b0, 8'h00, 8'h00},
    '{8'h34, 1'b0, 3, 1'b0, 8'h00, 8'h00},
    '{8'hFE, 1'b0, 3, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b1, 3, 1'b0, 8'h00, 8'h00},
    '{8'h5A, 1'b1, 3, 1'b0, 8'h00, 8'h00}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Multiplication in GF(2^8). Reduction uses only the low eight bits of the polynomial,
  // so a polynomial without its top bit still gives an eight-bit result.
  function automatic logic [7:0] gf256_product(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = a[7] ? ((a << 1) ^ field_poly_q[7:0]) : (a << 1);
    end
    return acc;
  endfunction

  function automatic logic [7:0] coef_byte(int idx);
    if (idx < 8) return gen_low_q[8*idx +: 8];
    if (idx < 16) return gen_mid_q[8*(idx-8) +: 8];
    return gen_top_q;
  endfunction

  // Weight of tap j; coefficient 0 is unused when reversed, coefficient 16 otherwise.
  function automatic logic [7:0] tap_weight(int j);
    return gen_reversed_q ? coef_byte(j) : coef_byte(PARITY_N - j);
  endfunction

  function automatic logic [7:0] offset_byte(int idx);
    return (idx < 8) ? offset_low_q[8*idx +: 8] : offset_high_q[8*(idx-8) +: 8];
  endfunction

  // Advances the model remainder by one message symbol and lists the words that the
  // encoder owes for it: the echo, then the sixteen parity words if the symbol is last.
  function automatic void encode_word(logic [7:0] d, logic l);
    logic [7:0]         fb;
    rse_pkg::out_word_t w;
    predicted_words.delete();
    fb = d ^ remainder_q[0];
    for (int t = 0; t < PARITY_N - 1; t++)
      remainder_q[t] = remainder_q[t+1] ^ gf256_product(fb, tap_weight(t + 1));
    remainder_q[PARITY_N-1] = gf256_product(fb, tap_weight(PARITY_N));
    w.sym  = d;
    w.par  = 1'b0;
    w.last = 1'b0;
    predicted_words = {predicted_words, w};
    if (l) begin
      for (int t = 0; t < PARITY_N; t++) begin
        w.sym  = remainder_q[t] ^ offset_byte(t);
        w.par  = 1'b1;
        w.last = (t == PARITY_N - 1);
        predicted_words = {predicted_words, w};
      end
      foreach (remainder_q[t]) remainder_q[t] = '0;
    end
  endfunction

  function automatic void store_register(logic [rse_pkg::CFG_INDEX_W-1:0] idx,
                                         logic [63:0] v);
    case (idx)
      rse_pkg::CFG_FIELD_POLY:   field_poly_q   = v[8:0];
      rse_pkg::CFG_GEN_REVERSED: gen_reversed_q = v[0];
      rse_pkg::CFG_GEN_LOW:      gen_low_q      = v;
      rse_pkg::CFG_GEN_MID:      gen_mid_q      = v;
      rse_pkg::CFG_GEN_TOP:      gen_top_q      = v[7:0];
      rse_pkg::CFG_OFFSET_LOW:   offset_low_q   = v;
      rse_pkg::CFG_OFFSET_HIGH:  offset_high_q  = v;
      default: ;
    endcase
  endfunction

  // Offers one message word, with a random gap before it, and records what it owes once
  // the encoder has taken it. Valid stays high afterwards so back-to-back words flow.
  task automatic send_word(logic [7:0] d, logic l, bit typed, logic [7:0] echo_exp,
                           logic [7:0] parity_exp);
    rse_pkg::out_word_t w;
    while ($urandom_range(99) < src_idle_pct) begin
      // Junk on the data lines while valid is low must be ignored.
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(255));
      s_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_word(d, l);
    if (typed) begin
      w = '{sym: echo_exp, par: 1'b0, last: 1'b0};
      code_words_due = {code_words_due, w};
      if (l) begin
        for (int t = 0; t < PARITY_N; t++) begin
          w = '{sym: parity_exp, par: 1'b1, last: (t == PARITY_N - 1)};
          code_words_due = {code_words_due, w};
        end
      end
    end else begin
      code_words_due = {code_words_due, predicted_words};
    end
  endtask

  // Stops offering and waits until the encoder has delivered every word it owes, plus a
  // margin for its output pipeline to settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (code_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rse_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    store_register(idx, v);
  endtask

  // Writes a whole setting while the encoder is idle, plus a write to the spare index.
  task automatic apply_config(reg_set_t c);
    wait_drained();
    write_reg(rse_pkg::CFG_FIELD_POLY, {55'd0, c.poly});
    write_reg(rse_pkg::CFG_GEN_REVERSED, {63'd0, c.rev});
    write_reg(rse_pkg::CFG_GEN_LOW, c.gen_low);
    write_reg(rse_pkg::CFG_GEN_MID, c.gen_mid);
    write_reg(rse_pkg::CFG_GEN_TOP, {56'd0, c.gen_top});
    write_reg(rse_pkg::CFG_OFFSET_LOW, c.off_low);
    write_reg(rse_pkg::CFG_OFFSET_HIGH, c.off_high);
    write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic note_mismatch(string what, rse_pkg::out_word_t want);
    if (mismatches < 10)
      $display("%0t: %s: expected sym %02h parity %0b last %0b,",
               $realtime, what, want.sym, want.par, want.last,
               " got sym %02h parity %0b last %0b", m_tdata, m_tuser, m_tlast);
    mismatches++;
  endtask

  // Receiver: random back-pressure, and on request one long hold-off counted here so
  // that the encoder fills up and has to stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Every word the encoder hands over is compared with the oldest word it owes.
  always @(posedge clk) begin
    rse_pkg::out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (code_words_due.size() == 0) begin
        want = '0;
        note_mismatch("word with nothing owed", want);
      end else begin
        want = code_words_due.pop_front();
        if (want.sym !== m_tdata || want.par !== m_tuser || want.last !== m_tlast)
          note_mismatch("wrong word", want);
      end
    end
  end

  initial begin
    reg_set_t cfg;
    int       cur_setting;
    int       sent;
    int       len;
    bit       held;

    // The model starts from the register values and remainder given after reset.
    cfg = directed_sets[0];
    field_poly_q   = cfg.poly;
    gen_reversed_q = cfg.rev;
    gen_low_q      = cfg.gen_low;
    gen_mid_q      = cfg.gen_mid;
    gen_top_q      = cfg.gen_top;
    offset_low_q   = cfg.off_low;
    offset_high_q  = cfg.off_high;
    foreach (remainder_q[t]) remainder_q[t] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: field extremes, single-symbol codewords and extreme settings.
    cur_setting = 0;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].setting != cur_setting) begin
        cur_setting = directed_rows[r].setting;
        apply_config(directed_sets[cur_setting]);
      end
      send_word(directed_rows[r].data, directed_rows[r].last, directed_rows[r].typed,
                directed_rows[r].echo_exp, directed_rows[r].parity_exp);
    end

    // Random part in three phases of idling. Each phase starts from a fresh random
    // setting; the second one uses polynomials without the top bit.
    held = 1'b0;
    for (int p = 0; p < 3; p++) begin
      src_idle_pct = (p == 0) ? 13 : (p == 1) ? 64 : 0;
      snk_idle_pct = (p == 0) ? 64 : (p == 1) ? 13 : 0;
      cfg.poly     = (p == 1) ? 9'($urandom_range(0, 255)) : 9'($urandom_range(256, 511));
      cfg.rev      = (p == 2) ? 1'($urandom_range(1)) : (p == 0);
      cfg.gen_low  = {$urandom, $urandom};
      cfg.gen_mid  = {$urandom, $urandom};
      cfg.gen_top  = 8'($urandom_range(255));
      cfg.off_low  = {$urandom, $urandom};
      cfg.off_high = {$urandom, $urandom};
      apply_config(cfg);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        // Mostly short codewords, so parity bursts are frequent; now and then a long one.
        len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (p == 0 && !held && sent > 30) begin
          // A long codeword offered straight into a long receiver hold-off.
          held = 1'b1;
          len = 40;
          hold_requests++;
        end
        for (int i = 0; i < len; i++)
          send_word(8'($urandom_range(255)), i == len - 1, 1'b0, 8'h00, 8'h00);
        sent += len;
      end
    end

    wait_drained();
    if (mismatches == 0 && code_words_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
